// File: sv/vbd_pkg.sv
// ----------------------------------------------------------------------------
// Volume box downsampler package
// Shared types, register indexes, defaults and helper functions.
// ----------------------------------------------------------------------------
package vbd_pkg;

  localparam int unsigned MaxInDimDefault = 1024;
  localparam int unsigned MaxOutXyDefault = 128;
  localparam int unsigned Lanes           = 4;
  localparam int unsigned SumW            = 64;
  localparam int unsigned MeanW           = 32;
  localparam int unsigned CfgIdxW         = 4;
  localparam int unsigned CfgDataW        = 32;

  localparam logic [CfgIdxW-1:0] RegInSizeX   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegInSizeY   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegInSizeZ   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegOutSizeX  = 4'd3;
  localparam logic [CfgIdxW-1:0] RegOutSizeY  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegOutSizeZ  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegComps     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSampleTyp = 4'd7;

  localparam logic [1:0] SampleU8  = 2'd0;
  localparam logic [1:0] SampleS8  = 2'd1;
  localparam logic [1:0] SampleS16 = 2'd2;
  localparam logic [1:0] SampleS32 = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean_0;
    logic signed [31:0] mean_1;
    logic signed [31:0] mean_2;
    logic signed [31:0] mean_3;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic [9:0]         cell_z;
    logic               volume_done;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic active;
    logic first;
    logic wr_en;
    logic div_start;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    StIdle,
    StBound,
    StRead,
    StAcc,
    StMul,
    StCount,
    StDiv,
    StOut
  } state_e;

  function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    r = (v == 32'd0) ? 32'd1 : v;
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic logic [SumW-1:0] take_sample(input logic [1:0] stype,
                                                  input logic [31:0] raw);
    logic [SumW-1:0] r;
    case (stype)
      SampleU8:  r = {56'd0, raw[7:0]};
      SampleS8:  r = {{56{raw[7]}}, raw[7:0]};
      SampleS16: r = {{48{raw[15]}}, raw[15:0]};
      SampleS32: r = {{32{raw[31]}}, raw};
      default:   r = {{32{raw[31]}}, raw};
    endcase
    return r;
  endfunction

endpackage

// File: sv/vbd_stream_if.sv
// ----------------------------------------------------------------------------
// Volume box downsampler stream interface
// Valid and ready handshake carrying one item of a given type.
// ----------------------------------------------------------------------------
interface vbd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/vbd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vbd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/vbd_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbd_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o,
  output logic            done_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW:0]   rem_q, rem_d, trial;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic            bit_s;

  always_comb begin
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    bit_s = trial >= {1'b0, den_q};
    rem_d = bit_s ? trial - {1'b0, den_q} : trial;
    quo_d = {quo_q[NumW-2:0], bit_s};
    cnt_d = cnt_q + CntW'(1);
    busy_d = busy_q && (cnt_q != CntW'(NumW - 1));
    done_d = done_q || (busy_q && !busy_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule

// File: sv/vbd_lane.sv
// ----------------------------------------------------------------------------
// Downsampler component lane
// Accumulator plane of one component and the divider that forms its mean.
// ----------------------------------------------------------------------------
module vbd_lane #(
  parameter int unsigned MaxOutXy = vbd_pkg::MaxOutXyDefault,
  parameter int unsigned CountW   = 33
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vbd_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [$clog2(MaxOutXy*MaxOutXy)-1:0] addr_i,
  input  logic [vbd_pkg::SumW-1:0]            sample_i,
  input  logic [CountW-1:0]                   count_i,
  output logic signed [vbd_pkg::MeanW-1:0]    mean_o,
  output logic                                done_o
);
  localparam int unsigned Depth = MaxOutXy * MaxOutXy;

  logic [vbd_pkg::SumW-1:0] rdata, new_sum, sum_q, mag;
  logic [vbd_pkg::SumW-1:0] quo;
  logic [vbd_pkg::MeanW-1:0] q32;

  assign new_sum = ctrl_i.first ? sample_i : rdata + sample_i;

  vbd_ram #(.Width(vbd_pkg::SumW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en && ctrl_i.active),
    .waddr_i (addr_i),
    .wdata_i (new_sum),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      sum_q <= new_sum;
    end
  end

  assign mag = sum_q[vbd_pkg::SumW-1] ? -sum_q : sum_q;

  vbd_div #(.NumW(vbd_pkg::SumW), .DenW(CountW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_start),
    .num_i   (mag),
    .den_i   (count_i),
    .quo_o   (quo),
    .done_o  (done_o)
  );

  assign q32 = quo[vbd_pkg::MeanW-1:0];
  assign mean_o = !ctrl_i.active ? '0 :
                  (sum_q[vbd_pkg::SumW-1] ? -q32 : q32);
endmodule

// File: sv/volume_box_downsampler_core.sv
// ----------------------------------------------------------------------------
// Volume box downsampler core
// Box-filter mean over output cells of a 2D or 3D voxel stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload      Handshake
// in_i     sink       in_item_t    valid/ready
// out_o    source     out_item_t   valid/ready
// cfg_i    sink       cfg_item_t   valid/ready, always ready
//
// For every voxel, closing a cell or not, the cell bound dividers run before
// the accumulator is read in StRead and updated in StAcc.
// A voxel that closes a cell then forms the count in StMul and StCount, starts
// the 64-bit mean dividers, which run in all four lanes at once, and loads
// the output register.
// No clearing pass after reset: a cell is overwritten by its first voxel.
// A result waits in the output register; a later result stalls only there.
module volume_box_downsampler_core #(
  parameter int unsigned MaxInDim = vbd_pkg::MaxInDimDefault,
  parameter int unsigned MaxOutXy = vbd_pkg::MaxOutXyDefault
) (
  input logic clk_i,
  input logic rst_ni,
  vbd_stream_if.sink   in_i,
  vbd_stream_if.source out_o,
  vbd_stream_if.sink   cfg_i
);
  localparam int unsigned SW     = $clog2(MaxInDim + 1);
  localparam int unsigned BW     = 2 * SW;
  localparam int unsigned CountW = 3 * SW;
  localparam int unsigned AW     = $clog2(MaxOutXy * MaxOutXy);
  localparam int unsigned Lanes  = vbd_pkg::Lanes;

  logic [10:0] in_x_q, in_y_q, in_z_q, out_z_q;
  logic [7:0]  out_x_q, out_y_q;
  logic [2:0]  comps_q;
  logic [1:0]  stype_q;

  logic [SW-1:0] ix, iy, iz, ox, oy, oz;
  logic [2:0]    nc;

  vbd_pkg::state_e state_q, state_d;
  logic [SW-1:0] vx_q, vy_q, vz_q, cx_q, cy_q, cz_q;
  logic [SW-1:0] vx_d, vy_d, vz_d, cx_d, cy_d, cz_d;
  logic [vbd_pkg::SumW-1:0] smp_q [Lanes];
  logic [31:0] raw [Lanes];

  logic [BW-1:0] bnum [6];
  logic [SW-1:0] bden [6];
  logic [BW-1:0] bquo [6];
  logic [5:0]    bdone;
  logic [SW-1:0] bnd [6];

  logic first, last, cfg_wr, accept, bnd_start, acc_en, load_out;
  logic vdone_q;
  logic div_go_q;
  logic [SW-1:0] ocx_q, ocy_q, ocz_q;
  logic [SW-1:0] dx_q, dy_q, dz_q;
  logic [BW-1:0] prod_q;
  logic [CountW-1:0] count_q, count_raw;
  logic [AW-1:0] addr;
  logic [Lanes-1:0] ldone;
  logic signed [vbd_pkg::MeanW-1:0] mean [Lanes];
  vbd_pkg::lane_ctrl_t lctrl [Lanes];
  vbd_pkg::out_item_t out_q;
  logic ovalid_q;

  // Effective sizes after clamping
  always_comb begin
    ix = SW'(vbd_pkg::clamp_size(32'(in_x_q), 32'(MaxInDim)));
    iy = SW'(vbd_pkg::clamp_size(32'(in_y_q), 32'(MaxInDim)));
    iz = SW'(vbd_pkg::clamp_size(32'(in_z_q), 32'(MaxInDim)));
    ox = SW'(vbd_pkg::clamp_size(32'(out_x_q), 32'(MaxOutXy)));
    oy = SW'(vbd_pkg::clamp_size(32'(out_y_q), 32'(MaxOutXy)));
    oz = SW'(vbd_pkg::clamp_size(32'(out_z_q), 32'(MaxInDim)));
    if (ox > ix) begin
      ox = ix;
    end
    if (oy > iy) begin
      oy = iy;
    end
    if (oz > iz) begin
      oz = iz;
    end
    nc = 3'(vbd_pkg::clamp_size(32'(comps_q), 32'(Lanes)));
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_wr = cfg_i.valid && (cfg_i.data.index < 4'(vbd_pkg::RegSampleTyp + 4'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_x_q  <= 11'd1;
      in_y_q  <= 11'd1;
      in_z_q  <= 11'd1;
      out_x_q <= 8'd1;
      out_y_q <= 8'd1;
      out_z_q <= 11'd1;
      comps_q <= 3'd1;
      stype_q <= vbd_pkg::SampleU8;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        vbd_pkg::RegInSizeX:   in_x_q  <= cfg_i.data.value[10:0];
        vbd_pkg::RegInSizeY:   in_y_q  <= cfg_i.data.value[10:0];
        vbd_pkg::RegInSizeZ:   in_z_q  <= cfg_i.data.value[10:0];
        vbd_pkg::RegOutSizeX:  out_x_q <= cfg_i.data.value[7:0];
        vbd_pkg::RegOutSizeY:  out_y_q <= cfg_i.data.value[7:0];
        vbd_pkg::RegOutSizeZ:  out_z_q <= cfg_i.data.value[10:0];
        vbd_pkg::RegComps:     comps_q <= cfg_i.data.value[2:0];
        vbd_pkg::RegSampleTyp: stype_q <= cfg_i.data.value[1:0];
        default: ;
      endcase
    end
  end

  // Cell bounds, recomputed for every voxel from the cell indices
  always_comb begin
    bnum[0] = BW'(cx_q) * BW'(ix);
    bnum[1] = (BW'(cx_q) + BW'(1)) * BW'(ix);
    bnum[2] = BW'(cy_q) * BW'(iy);
    bnum[3] = (BW'(cy_q) + BW'(1)) * BW'(iy);
    bnum[4] = BW'(cz_q) * BW'(iz);
    bnum[5] = (BW'(cz_q) + BW'(1)) * BW'(iz);
    bden[0] = ox;
    bden[1] = ox;
    bden[2] = oy;
    bden[3] = oy;
    bden[4] = oz;
    bden[5] = oz;
  end

  for (genvar b = 0; b < 6; b++) begin : g_bound
    vbd_div #(.NumW(BW), .DenW(SW)) u_bdiv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (bnd_start),
      .num_i   (bnum[b]),
      .den_i   (bden[b]),
      .quo_o   (bquo[b]),
      .done_o  (bdone[b])
    );
    assign bnd[b] = bquo[b][SW-1:0];
  end

  assign first = (vx_q == bnd[0]) && (vy_q == bnd[2]) && (vz_q == bnd[4]);
  assign last  = (vx_q + SW'(1) == bnd[1]) && (vy_q + SW'(1) == bnd[3]) &&
                 (vz_q + SW'(1) == bnd[5]);

  // Position advance
  always_comb begin
    vx_d = vx_q + SW'(1);
    vy_d = vy_q;
    vz_d = vz_q;
    cx_d = (vx_q + SW'(1) == bnd[1]) ? cx_q + SW'(1) : cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    if (vx_d >= ix) begin
      vx_d = '0;
      cx_d = '0;
      vy_d = vy_q + SW'(1);
      if (vy_q + SW'(1) == bnd[3]) begin
        cy_d = cy_q + SW'(1);
      end
      if (vy_d >= iy) begin
        vy_d = '0;
        cy_d = '0;
        vz_d = vz_q + SW'(1);
        if (vz_q + SW'(1) == bnd[5]) begin
          cz_d = cz_q + SW'(1);
        end
        if (vz_d >= iz) begin
          vz_d = '0;
          cz_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
      vz_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else if (cfg_wr) begin
      vx_q <= '0;
      vy_q <= '0;
      vz_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else if (acc_en) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
      vz_q <= vz_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end
  end

  assign raw[0] = in_i.data.sample_0;
  assign raw[1] = in_i.data.sample_1;
  assign raw[2] = in_i.data.sample_2;
  assign raw[3] = in_i.data.sample_3;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int l = 0; l < Lanes; l++) begin
        smp_q[l] <= vbd_pkg::take_sample(stype_q, raw[l]);
      end
    end
    if (acc_en) begin
      ocx_q   <= cx_q;
      ocy_q   <= cy_q;
      ocz_q   <= cz_q;
      vdone_q <= (cx_q + SW'(1) == ox) && (cy_q + SW'(1) == oy) && (cz_q + SW'(1) == oz);
      dx_q    <= bnd[1] - bnd[0];
      dy_q    <= bnd[3] - bnd[2];
      dz_q    <= bnd[5] - bnd[4];
    end
    if (state_q == vbd_pkg::StMul) begin
      prod_q <= BW'(dx_q) * BW'(dy_q);
    end
    if (state_q == vbd_pkg::StCount) begin
      count_q <= (count_raw == '0) ? CountW'(1) : count_raw;
    end
  end

  assign count_raw = CountW'(prod_q) * CountW'(dz_q);
  assign addr = AW'(cy_q) * AW'(MaxOutXy) + AW'(cx_q);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    accept    = 1'b0;
    bnd_start = 1'b0;
    acc_en    = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      vbd_pkg::StIdle: begin
        if (in_i.valid) begin
          accept    = 1'b1;
          bnd_start = 1'b1;
          state_d   = vbd_pkg::StBound;
        end
      end
      vbd_pkg::StBound: begin
        if (&bdone) begin
          state_d = vbd_pkg::StRead;
        end
      end
      vbd_pkg::StRead: state_d = vbd_pkg::StAcc;
      vbd_pkg::StAcc: begin
        acc_en  = 1'b1;
        state_d = last ? vbd_pkg::StMul : vbd_pkg::StIdle;
      end
      vbd_pkg::StMul: state_d = vbd_pkg::StCount;
      vbd_pkg::StCount: begin
        state_d = vbd_pkg::StDiv;
      end
      vbd_pkg::StDiv: begin
        if (&ldone && !div_go_q) begin
          state_d = vbd_pkg::StOut;
        end
      end
      vbd_pkg::StOut: begin
        if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = vbd_pkg::StIdle;
        end
      end
      default: state_d = vbd_pkg::StIdle;
    endcase
  end

  // The mean dividers start on the first cycle in StDiv.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vbd_pkg::StIdle;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == vbd_pkg::StCount);
    end
  end

  assign in_i.ready = (state_q == vbd_pkg::StIdle);

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign lctrl[l].active    = (3'(l) < nc);
    assign lctrl[l].first     = first;
    assign lctrl[l].wr_en     = acc_en;
    assign lctrl[l].div_start = div_go_q;

    vbd_lane #(.MaxOutXy(MaxOutXy), .CountW(CountW)) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lctrl[l]),
      .addr_i   (addr),
      .sample_i (smp_q[l]),
      .count_i  (count_q),
      .mean_o   (mean[l]),
      .done_o   (ldone[l])
    );
  end

  // Output register, merging the lane means with the cell coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.mean_0      <= mean[0];
      out_q.mean_1      <= mean[1];
      out_q.mean_2      <= mean[2];
      out_q.mean_3      <= mean[3];
      out_q.cell_x      <= 7'(ocx_q);
      out_q.cell_y      <= 7'(ocy_q);
      out_q.cell_z      <= 10'(ocz_q);
      out_q.volume_done <= vdone_q;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = out_q;
endmodule
